// ===== hdl/pmc_pkg.sv =====
// Shared types, constants and the axis clamp function for the mouse packet cursor unit.
`timescale 1ns / 1ps

package pmc_pkg;

	// Coordinate and screen size widths
	localparam int COORD_WIDTH = 13;
	localparam int SIZE_W      = 13;
	localparam int COORD_MAX   = (1 << COORD_WIDTH) - 1;
	localparam int CALC_W      = ((COORD_WIDTH > SIZE_W) ? COORD_WIDTH : SIZE_W) + 2;

	typedef logic [COORD_WIDTH-1:0]   coord_t;
	typedef logic [SIZE_W-1:0]        size_t;
	typedef logic signed [CALC_W-1:0] calc_t;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = CFG_IDX_W'(1);

	// Reset values
	localparam size_t RESET_WIDTH  = SIZE_W'(1024);
	localparam size_t RESET_HEIGHT = SIZE_W'(768);
	localparam coord_t RESET_X = (512 > COORD_MAX) ? coord_t'(COORD_MAX) : coord_t'(512);
	localparam coord_t RESET_Y = (384 > COORD_MAX) ? coord_t'(COORD_MAX) : coord_t'(384);

	// First byte bit positions
	localparam int BIT_LEFT   = 0;
	localparam int BIT_RIGHT  = 1;
	localparam int BIT_MIDDLE = 2;
	localparam int BIT_SYNC   = 3;
	localparam int BIT_X_SIGN = 4;
	localparam int BIT_Y_SIGN = 5;

	// Clamp constants
	localparam calc_t EDGE_MARGIN = calc_t'(8);
	localparam calc_t COORD_MAX_C = calc_t'(COORD_MAX);

	// Clamp a new coordinate below 0 to 0, at or past size to size minus 8,
	// then saturate into the coordinate range
	function automatic coord_t clamp_axis(calc_t v, size_t size);
		calc_t size_ext;
		calc_t w;
		size_ext = calc_t'(size);
		w = v;
		if (w < 0) begin
			w = '0;
		end
		if (w >= size_ext) begin
			w = size_ext - EDGE_MARGIN;
		end
		if (w < 0) begin
			w = '0;
		end
		if (w > COORD_MAX_C) begin
			w = COORD_MAX_C;
		end
		return w[COORD_WIDTH-1:0];
	endfunction

endpackage

// ===== hdl/pmc_byte_if.sv =====
// Valid/ready channel carrying one raw mouse byte.
`timescale 1ns / 1ps

interface pmc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

// ===== hdl/pmc_cursor_if.sv =====
// Valid/ready channel carrying one cursor position and button state.
`timescale 1ns / 1ps

interface pmc_cursor_if;
	import pmc_pkg::*;
	logic   valid;
	logic   ready;
	coord_t cursor_x;
	coord_t cursor_y;
	logic   left_button;
	logic   right_button;
	logic   middle_button;

	modport source (output valid, output cursor_x, output cursor_y, output left_button,
		output right_button, output middle_button, input ready);
	modport sink (input valid, input cursor_x, input cursor_y, input left_button,
		input right_button, input middle_button, output ready);
endinterface

// ===== hdl/ps2_mouse_packet_cursor_unit.sv =====
// Top level: PS/2 mouse packet decoder with clamped cursor tracking.
//
//   channel  dir  payload                                        transfer
//   rx       in   data_byte[7:0]                                 valid & ready
//   cursor   out  cursor_x, cursor_y, left/right/middle_button   valid & ready
//   cfg      in   cfg_index[1:0], cfg_data[12:0]                 cfg_we
//
// One byte per cycle unless a packet's third byte meets a full output: each byte
// is held in the input register, then the packet decode, one add and the clamp
// write the state and the result register, which holds the packet result.
// Reset clears the packet counter and valids; cursor returns to mid screen.
// A result held by a stalled sink blocks only a third byte behind it.
`timescale 1ns / 1ps

module ps2_mouse_packet_cursor_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	pmc_byte_if.sink                          rx,
	pmc_cursor_if.source                      cursor,
	input  logic                              cfg_we,
	input  logic [pmc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pmc_pkg::SIZE_W-1:0]        cfg_data
);
	import pmc_pkg::*;

	localparam logic [1:0] IDX_FIRST  = 2'd0;
	localparam logic [1:0] IDX_SECOND = 2'd1;
	localparam logic [1:0] IDX_THIRD  = 2'd2;

	logic       valid_s1;
	logic [7:0] byte_s1;

	logic [1:0] byte_index_q;
	logic [7:0] first_byte_q;
	logic [7:0] second_byte_q;
	coord_t     pos_x_q;
	coord_t     pos_y_q;
	size_t      width_q;
	size_t      height_q;

	logic   out_valid_q;
	coord_t out_x_q;
	coord_t out_y_q;
	logic   out_left_q;
	logic   out_right_q;
	logic   out_middle_q;

	logic   completes;
	logic   out_free;
	logic   advance;
	calc_t  dx;
	calc_t  dy;
	calc_t  sum_x;
	calc_t  sum_y;
	coord_t new_x;
	coord_t new_y;

	// Handshake: a stage-1 byte moves on unless it closes a packet into a full output
	assign completes = valid_s1 && byte_index_q[1];
	assign out_free  = !out_valid_q || cursor.ready;
	assign advance   = valid_s1 && (!completes || out_free);
	assign rx.ready  = !valid_s1 || advance;

	// Sign-extend deltas and compute the new clamped position
	assign dx    = calc_t'($signed({first_byte_q[BIT_X_SIGN], second_byte_q}));
	assign dy    = calc_t'($signed({first_byte_q[BIT_Y_SIGN], byte_s1}));
	assign sum_x = calc_t'(pos_x_q) + dx;
	assign sum_y = calc_t'(pos_y_q) - dy;
	assign new_x = clamp_axis(sum_x, width_q);
	assign new_y = clamp_axis(sum_y, height_q);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.data_byte;
		end
	end

	// Screen size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RESET_WIDTH;
			height_q <= RESET_HEIGHT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCREEN_WIDTH:  width_q  <= cfg_data;
				REG_SCREEN_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Packet assembly and cursor update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q  <= IDX_FIRST;
			first_byte_q  <= '0;
			second_byte_q <= '0;
			pos_x_q       <= RESET_X;
			pos_y_q       <= RESET_Y;
		end else if (advance) begin
			case (byte_index_q)
				IDX_FIRST: begin
					// drop bytes without the sync bit to resync
					if (byte_s1[BIT_SYNC]) begin
						first_byte_q <= byte_s1;
						byte_index_q <= IDX_SECOND;
					end
				end
				IDX_SECOND: begin
					second_byte_q <= byte_s1;
					byte_index_q  <= IDX_THIRD;
				end
				default: begin
					byte_index_q <= IDX_FIRST;
					pos_x_q      <= new_x;
					pos_y_q      <= new_y;
				end
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && completes) begin
			out_valid_q <= 1'b1;
		end else if (cursor.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && completes) begin
			out_x_q      <= new_x;
			out_y_q      <= new_y;
			out_left_q   <= first_byte_q[BIT_LEFT];
			out_right_q  <= first_byte_q[BIT_RIGHT];
			out_middle_q <= first_byte_q[BIT_MIDDLE];
		end
	end

	assign cursor.valid         = out_valid_q;
	assign cursor.cursor_x      = out_x_q;
	assign cursor.cursor_y      = out_y_q;
	assign cursor.left_button   = out_left_q;
	assign cursor.right_button  = out_right_q;
	assign cursor.middle_button = out_middle_q;

endmodule
